// ===== hdl/vcr_pkg.sv =====
// ----------------------------------------------------------------------------
// vcr_pkg
// Shared types, constants and the divider step for the visible chunk range
// block.
// ----------------------------------------------------------------------------
package vcr_pkg;

  // Field widths fixed by the item format.
  localparam int COORD_W   = 16;
  localparam int VIEW_W    = 12;
  localparam int GRID_W    = 16;
  localparam int CFG_W     = 8;
  localparam int CHUNK_W   = 2 * CFG_W;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  // The 8.8 parallax product is taken down by this many fraction bits.
  localparam int PARALLAX_FRAC = 8;
  localparam int PROD_W        = 2 * COORD_W + 1;

  // Pixel edges stay within 25 bits signed; magnitudes fit in 24 bits.
  localparam int EDGE_W    = 25;
  localparam int MAG_W     = EDGE_W - 1;
  localparam int CALC_W    = EDGE_W + 1;

  // Divider organisation: a few quotient bits per register stage.
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = MAG_W / BITS_PER_STAGE;

  // Stage A, stage B, divider stages, output register.
  localparam int PIPE_DEPTH = DIV_STAGES + 3;

  typedef enum logic [1:0] {
    REG_TILE_PIXEL_WIDTH  = 2'd0,
    REG_TILE_PIXEL_HEIGHT = 2'd1,
    REG_CHUNK_TILES_WIDE  = 2'd2,
    REG_CHUNK_TILES_HIGH  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] camera_x;
    logic signed [COORD_W-1:0] camera_y;
    logic [VIEW_W-1:0]         view_width;
    logic [VIEW_W-1:0]         view_height;
    logic [COORD_W-1:0]        parallax_x;
    logic [COORD_W-1:0]        parallax_y;
    logic signed [COORD_W-1:0] layer_offset_x;
    logic signed [COORD_W-1:0] layer_offset_y;
    logic [GRID_W-1:0]         grid_columns;
    logic [GRID_W-1:0]         grid_rows;
  } req_t;

  typedef struct packed {
    logic              visible;
    logic [GRID_W-1:0] first_column;
    logic [GRID_W-1:0] first_row;
    logic [GRID_W-1:0] last_column;
    logic [GRID_W-1:0] last_row;
  } rsp_t;

  // A pixel edge split into sign and the magnitude that is divided.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } edge_t;

  // Per-item data that rides alongside the dividers.
  typedef struct packed {
    logic              bad;
    logic [GRID_W-1:0] cols;
    logic [GRID_W-1:0] rows;
  } side_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] rem;
    logic [MAG_W-1:0]   dq;
  } div_state_t;

  // A handful of restoring division steps; quotient bits shift into dq.
  function automatic div_state_t div_chunk(div_state_t s, logic [CHUNK_W-1:0] d);
    div_state_t     r;
    logic [CHUNK_W:0] t;
    logic           ge;
    r = s;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      t  = {r.rem, r.dq[MAG_W-1]};
      ge = (t >= {1'b0, d});
      r.rem = ge ? CHUNK_W'(t - {1'b0, d}) : t[CHUNK_W-1:0];
      r.dq  = {r.dq[MAG_W-2:0], ge};
    end
    return r;
  endfunction

endpackage

// ===== hdl/vcr_if.sv =====
// ----------------------------------------------------------------------------
// vcr_if
// Valid/ready channels for culling requests and their results.
// ----------------------------------------------------------------------------
interface vcr_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [vcr_pkg::COORD_W-1:0]  camera_x;
  logic signed [vcr_pkg::COORD_W-1:0]  camera_y;
  logic [vcr_pkg::VIEW_W-1:0]          view_width;
  logic [vcr_pkg::VIEW_W-1:0]          view_height;
  logic [vcr_pkg::COORD_W-1:0]         parallax_x;
  logic [vcr_pkg::COORD_W-1:0]         parallax_y;
  logic signed [vcr_pkg::COORD_W-1:0]  layer_offset_x;
  logic signed [vcr_pkg::COORD_W-1:0]  layer_offset_y;
  logic [vcr_pkg::GRID_W-1:0]          grid_columns;
  logic [vcr_pkg::GRID_W-1:0]          grid_rows;

  modport source (output valid, camera_x, camera_y, view_width, view_height,
                  parallax_x, parallax_y, layer_offset_x, layer_offset_y,
                  grid_columns, grid_rows, input ready);
  modport sink   (input valid, camera_x, camera_y, view_width, view_height,
                  parallax_x, parallax_y, layer_offset_x, layer_offset_y,
                  grid_columns, grid_rows, output ready);
endinterface

interface vcr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       visible;
  logic [vcr_pkg::GRID_W-1:0] first_column;
  logic [vcr_pkg::GRID_W-1:0] first_row;
  logic [vcr_pkg::GRID_W-1:0] last_column;
  logic [vcr_pkg::GRID_W-1:0] last_row;

  modport source (output valid, visible, first_column, first_row, last_column,
                  last_row, input ready);
  modport sink   (input valid, visible, first_column, first_row, last_column,
                  last_row, output ready);
endinterface

// ===== hdl/vcr_regs.sv =====
// ----------------------------------------------------------------------------
// vcr_regs
// APB configuration registers and the derived chunk pixel sizes.
// ----------------------------------------------------------------------------
module vcr_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vcr_pkg::APB_AW-1:0]    paddr,
  input  logic [vcr_pkg::APB_DW-1:0]    pwdata,
  output logic [vcr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output logic [vcr_pkg::CHUNK_W-1:0]   chunk_w,
  output logic [vcr_pkg::CHUNK_W-1:0]   chunk_h
);

  logic [vcr_pkg::CFG_W-1:0] tile_w;
  logic [vcr_pkg::CFG_W-1:0] tile_h;
  logic [vcr_pkg::CFG_W-1:0] tiles_wide;
  logic [vcr_pkg::CFG_W-1:0] tiles_high;
  vcr_pkg::reg_idx_t         idx;
  logic                      wr;

  assign pready = 1'b1;
  assign idx    = vcr_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  // Register writes; the chunk sizes are registered from the written values.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_w     <= 8'd16;
      tile_h     <= 8'd16;
      tiles_wide <= 8'd16;
      tiles_high <= 8'd16;
      chunk_w    <= 16'd256;
      chunk_h    <= 16'd256;
    end else begin
      if (wr) begin
        unique case (idx)
          vcr_pkg::REG_TILE_PIXEL_WIDTH:  tile_w     <= pwdata[vcr_pkg::CFG_W-1:0];
          vcr_pkg::REG_TILE_PIXEL_HEIGHT: tile_h     <= pwdata[vcr_pkg::CFG_W-1:0];
          vcr_pkg::REG_CHUNK_TILES_WIDE:  tiles_wide <= pwdata[vcr_pkg::CFG_W-1:0];
          vcr_pkg::REG_CHUNK_TILES_HIGH:  tiles_high <= pwdata[vcr_pkg::CFG_W-1:0];
          default: ;
        endcase
      end
      chunk_w <= tiles_wide * tile_w;
      chunk_h <= tiles_high * tile_h;
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      vcr_pkg::REG_TILE_PIXEL_WIDTH:  prdata = vcr_pkg::APB_DW'(tile_w);
      vcr_pkg::REG_TILE_PIXEL_HEIGHT: prdata = vcr_pkg::APB_DW'(tile_h);
      vcr_pkg::REG_CHUNK_TILES_WIDE:  prdata = vcr_pkg::APB_DW'(tiles_wide);
      vcr_pkg::REG_CHUNK_TILES_HIGH:  prdata = vcr_pkg::APB_DW'(tiles_high);
      default:                        prdata = '0;
    endcase
  end

endmodule

// ===== hdl/vcr_front.sv =====
// ----------------------------------------------------------------------------
// vcr_front
// Parallax multiply, then view edges in layer pixels split into sign and
// magnitude for the floor dividers.
// ----------------------------------------------------------------------------
module vcr_front (
  input  logic                        clk,
  input  logic                        en,
  input  vcr_pkg::req_t               req,
  input  logic [vcr_pkg::CHUNK_W-1:0] chunk_w,
  input  logic [vcr_pkg::CHUNK_W-1:0] chunk_h,
  output vcr_pkg::edge_t              min_x,
  output vcr_pkg::edge_t              max_x,
  output vcr_pkg::edge_t              min_y,
  output vcr_pkg::edge_t              max_y,
  output vcr_pkg::side_t              side
);

  logic signed [vcr_pkg::PROD_W-1:0]  prod_x;
  logic signed [vcr_pkg::PROD_W-1:0]  prod_y;
  vcr_pkg::req_t                      req_a;
  logic signed [vcr_pkg::CALC_W-1:0]  lo_x;
  logic signed [vcr_pkg::CALC_W-1:0]  lo_y;
  logic signed [vcr_pkg::CALC_W-1:0]  hi_x;
  logic signed [vcr_pkg::CALC_W-1:0]  hi_y;

  // Stage A: camera times parallax.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= vcr_pkg::PROD_W'(req.camera_x) *
                $signed({1'b0, req.parallax_x});
      prod_y <= vcr_pkg::PROD_W'(req.camera_y) *
                $signed({1'b0, req.parallax_y});
      req_a  <= req;
    end
  end

  // Floor by 256 is an arithmetic shift; then offset and view size.
  always_comb begin
    lo_x = vcr_pkg::CALC_W'(prod_x >>> vcr_pkg::PARALLAX_FRAC) -
           vcr_pkg::CALC_W'(req_a.layer_offset_x);
    lo_y = vcr_pkg::CALC_W'(prod_y >>> vcr_pkg::PARALLAX_FRAC) -
           vcr_pkg::CALC_W'(req_a.layer_offset_y);
    hi_x = lo_x + $signed({14'd0, req_a.view_width}) - 26'sd1;
    hi_y = lo_y + $signed({14'd0, req_a.view_height}) - 26'sd1;
  end

  // Stage B: a negative edge is divided as its one's complement.
  always_ff @(posedge clk) begin
    if (en) begin
      min_x.neg <= lo_x[vcr_pkg::CALC_W-1];
      min_x.mag <= lo_x[vcr_pkg::CALC_W-1] ? ~lo_x[vcr_pkg::MAG_W-1:0]
                                             : lo_x[vcr_pkg::MAG_W-1:0];
      min_y.neg <= lo_y[vcr_pkg::CALC_W-1];
      min_y.mag <= lo_y[vcr_pkg::CALC_W-1] ? ~lo_y[vcr_pkg::MAG_W-1:0]
                                             : lo_y[vcr_pkg::MAG_W-1:0];
      max_x.neg <= hi_x[vcr_pkg::CALC_W-1];
      max_x.mag <= hi_x[vcr_pkg::CALC_W-1] ? ~hi_x[vcr_pkg::MAG_W-1:0]
                                             : hi_x[vcr_pkg::MAG_W-1:0];
      max_y.neg <= hi_y[vcr_pkg::CALC_W-1];
      max_y.mag <= hi_y[vcr_pkg::CALC_W-1] ? ~hi_y[vcr_pkg::MAG_W-1:0]
                                             : hi_y[vcr_pkg::MAG_W-1:0];
      side.bad  <= (req_a.view_width == '0) || (req_a.view_height == '0) ||
                   (req_a.grid_columns == '0) || (req_a.grid_rows == '0) ||
                   (chunk_w == '0) || (chunk_h == '0);
      side.cols <= req_a.grid_columns;
      side.rows <= req_a.grid_rows;
    end
  end

endmodule

// ===== hdl/vcr_div.sv =====
// ----------------------------------------------------------------------------
// vcr_div
// Pipelined floor divider: restoring division of the edge magnitude, a few
// quotient bits per stage, with the sign carried alongside.
// ----------------------------------------------------------------------------
module vcr_div (
  input  logic                        clk,
  input  logic                        en,
  input  vcr_pkg::edge_t              edge_in,
  input  logic [vcr_pkg::CHUNK_W-1:0] divisor,
  output vcr_pkg::edge_t              quot
);

  vcr_pkg::div_state_t st  [vcr_pkg::DIV_STAGES];
  logic                neg [vcr_pkg::DIV_STAGES];
  vcr_pkg::div_state_t first;

  assign first.rem = '0;
  assign first.dq  = edge_in.mag;

  // Stage zero takes the fresh edge; later stages continue the previous one.
  always_ff @(posedge clk) begin
    if (en) begin
      st[0]  <= vcr_pkg::div_chunk(first, divisor);
      neg[0] <= edge_in.neg;
      for (int s = 1; s < vcr_pkg::DIV_STAGES; s++) begin
        st[s]  <= vcr_pkg::div_chunk(st[s-1], divisor);
        neg[s] <= neg[s-1];
      end
    end
  end

  assign quot.neg = neg[vcr_pkg::DIV_STAGES-1];
  assign quot.mag = st[vcr_pkg::DIV_STAGES-1].dq;

endmodule

// ===== hdl/vcr_clamp.sv =====
// ----------------------------------------------------------------------------
// vcr_clamp
// Restores floor quotients, rejects views outside the grid and clamps the
// chunk rectangle to it.
// ----------------------------------------------------------------------------
module vcr_clamp (
  input  vcr_pkg::edge_t q_min_x,
  input  vcr_pkg::edge_t q_max_x,
  input  vcr_pkg::edge_t q_min_y,
  input  vcr_pkg::edge_t q_max_y,
  input  vcr_pkg::side_t side,
  output vcr_pkg::rsp_t  rsp
);

  logic signed [vcr_pkg::EDGE_W-1:0] c0x, c1x, c0y, c1y;
  logic signed [vcr_pkg::EDGE_W-1:0] cols_s, rows_s;
  logic                              outside;

  // A negative quotient was formed from the complemented edge.
  always_comb begin
    c0x = q_min_x.neg ? $signed(~{1'b0, q_min_x.mag}) : $signed({1'b0, q_min_x.mag});
    c1x = q_max_x.neg ? $signed(~{1'b0, q_max_x.mag}) : $signed({1'b0, q_max_x.mag});
    c0y = q_min_y.neg ? $signed(~{1'b0, q_min_y.mag}) : $signed({1'b0, q_min_y.mag});
    c1y = q_max_y.neg ? $signed(~{1'b0, q_max_y.mag}) : $signed({1'b0, q_max_y.mag});
    cols_s = $signed({9'd0, side.cols});
    rows_s = $signed({9'd0, side.rows});
    outside = c1x[vcr_pkg::EDGE_W-1] || c1y[vcr_pkg::EDGE_W-1] ||
              (c0x >= cols_s) || (c0y >= rows_s);

    // Nothing visible gives an all-zero rectangle.
    rsp = '0;
    if (!side.bad && !outside) begin
      rsp.visible      = 1'b1;
      rsp.first_column = c0x[vcr_pkg::EDGE_W-1] ? '0 : c0x[vcr_pkg::GRID_W-1:0];
      rsp.first_row    = c0y[vcr_pkg::EDGE_W-1] ? '0 : c0y[vcr_pkg::GRID_W-1:0];
      rsp.last_column  = (c1x >= cols_s) ? side.cols - 16'd1 : c1x[vcr_pkg::GRID_W-1:0];
      rsp.last_row     = (c1y >= rows_s) ? side.rows - 16'd1 : c1y[vcr_pkg::GRID_W-1:0];
    end
  end

endmodule

// ===== hdl/visible_chunk_range.sv =====
// ----------------------------------------------------------------------------
// visible_chunk_range
// Culls one tilemap layer's chunk grid against a camera view and returns the
// clamped inclusive chunk rectangle.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake      Carries
// req       in         valid/ready    camera, view, parallax, offset, grid
// rsp       out        valid/ready    visible flag and chunk rectangle
// apb       in         psel/penable   four 8-bit layout registers
//
// One request is taken every cycle while the output register is free or being taken.
// The request passes nine registers: multiply, edge, six divider stages of four
// quotient bits each, and the output register, where its result waits to be taken.
// The six-stage floor dividers make up most of the pipeline.
// Reset clears the valid bits and restores the registers to 16.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module visible_chunk_range (
  input  logic                       clk,
  input  logic                       rst,
  vcr_req_if.sink                    req,
  vcr_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vcr_pkg::APB_AW-1:0] paddr,
  input  logic [vcr_pkg::APB_DW-1:0] pwdata,
  output logic [vcr_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  logic [vcr_pkg::CHUNK_W-1:0] chunk_w, chunk_h;
  logic                        en;
  logic                        vld [vcr_pkg::PIPE_DEPTH];
  vcr_pkg::req_t               req_d;
  vcr_pkg::edge_t              min_x, max_x, min_y, max_y;
  vcr_pkg::edge_t              q_min_x, q_max_x, q_min_y, q_max_y;
  vcr_pkg::side_t              side_b;
  vcr_pkg::side_t              side_d [vcr_pkg::DIV_STAGES];
  vcr_pkg::rsp_t               res, res_q;

  vcr_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .chunk_w, .chunk_h
  );

  // The pipeline moves whenever the output register is free or being taken.
  assign en        = !vld[vcr_pkg::PIPE_DEPTH-1] || rsp.ready;
  assign req.ready = en && !rst;

  always_comb begin
    req_d.camera_x       = req.camera_x;
    req_d.camera_y       = req.camera_y;
    req_d.view_width     = req.view_width;
    req_d.view_height    = req.view_height;
    req_d.parallax_x     = req.parallax_x;
    req_d.parallax_y     = req.parallax_y;
    req_d.layer_offset_x = req.layer_offset_x;
    req_d.layer_offset_y = req.layer_offset_y;
    req_d.grid_columns   = req.grid_columns;
    req_d.grid_rows      = req.grid_rows;
  end

  vcr_front u_front (
    .clk, .en, .req(req_d), .chunk_w, .chunk_h,
    .min_x, .max_x, .min_y, .max_y, .side(side_b)
  );

  vcr_div u_div_min_x (.clk, .en, .edge_in(min_x), .divisor(chunk_w), .quot(q_min_x));
  vcr_div u_div_max_x (.clk, .en, .edge_in(max_x), .divisor(chunk_w), .quot(q_max_x));
  vcr_div u_div_min_y (.clk, .en, .edge_in(min_y), .divisor(chunk_h), .quot(q_min_y));
  vcr_div u_div_max_y (.clk, .en, .edge_in(max_y), .divisor(chunk_h), .quot(q_max_y));

  // Side data keeps pace with the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_b;
      for (int s = 1; s < vcr_pkg::DIV_STAGES; s++) begin
        side_d[s] <= side_d[s-1];
      end
    end
  end

  vcr_clamp u_clamp (
    .q_min_x, .q_max_x, .q_min_y, .q_max_y,
    .side(side_d[vcr_pkg::DIV_STAGES-1]), .rsp(res)
  );

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < vcr_pkg::PIPE_DEPTH; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= req.valid;
      for (int s = 1; s < vcr_pkg::PIPE_DEPTH; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      res_q <= res;
    end
  end

  assign rsp.valid        = vld[vcr_pkg::PIPE_DEPTH-1];
  assign rsp.visible      = res_q.visible;
  assign rsp.first_column = res_q.first_column;
  assign rsp.first_row    = res_q.first_row;
  assign rsp.last_column  = res_q.last_column;
  assign rsp.last_row     = res_q.last_row;

endmodule
